/* design/per_client_token_bucket_quota_macros.svh */
// Assertion macros shared by the quota block.
`ifndef PER_CLIENT_TOKEN_BUCKET_QUOTA_MACROS_SVH
`define PER_CLIENT_TOKEN_BUCKET_QUOTA_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PCTBQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define PCTBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pctbq_pkg.sv */
// Types, constants and helper functions of the per-client token bucket quota block.
`timescale 1ns / 1ps
package pctbq_pkg;

  localparam int CLIENTS_DEF  = 64;
  localparam int SLOT_FIELD_W = 6;
  localparam int RATE_W       = 32;
  localparam int TOKEN_W      = 34;
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 32;
  localparam int WHOLE_W      = 26;
  localparam int FRAC_W       = 8;
  localparam int KINDS        = 3;
  localparam int OP_W         = 3;
  localparam int PROD_W       = 2 * RATE_W;
  localparam int CFG_INDEX_W  = 2;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 1;

  localparam logic [RATE_W-1:0]  REQ_UNLIMITED_RATE = 32'd25600;
  localparam logic [TOKEN_W-1:0] FULL_UNLIMITED     = 34'h2_0000_0000;
  localparam logic [TOKEN_W-1:0] ONE_TOKEN          = 34'd256;

  typedef enum logic [OP_W-1:0] {
    OP_TICK,
    OP_CHK_PRODUCE,
    OP_CHK_FETCH,
    OP_CHK_REQUEST,
    OP_SET_PRODUCE,
    OP_SET_FETCH,
    OP_SET_REQUEST,
    OP_REMOVE
  } op_t;

  typedef enum logic [1:0] {
    KIND_PRODUCE,
    KIND_FETCH,
    KIND_REQUEST
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRODUCE_RATE,
    CFG_FETCH_RATE,
    CFG_REQUEST_RATE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [TOKEN_W-1:0] tokens;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   throttled;
  } bucket_t;

  // One table row holds the three buckets of a client
  typedef bucket_t [KINDS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic rate_unlimited(kind_t kind, logic [RATE_W-1:0] rate);
    return (rate == '0) || ((kind == KIND_REQUEST) && (rate >= REQ_UNLIMITED_RATE));
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic kind_t kind_of(op_t op);
    kind_t k;
    case (op)
      OP_CHK_PRODUCE, OP_SET_PRODUCE: k = KIND_PRODUCE;
      OP_CHK_FETCH,   OP_SET_FETCH:   k = KIND_FETCH;
      OP_CHK_REQUEST, OP_SET_REQUEST: k = KIND_REQUEST;
      default:                        k = KIND_PRODUCE;
    endcase
    return k;
  endfunction

  // Full bucket at the given rate; unlimited buckets sit above any burst
  function automatic bucket_t new_bucket(kind_t kind, logic [RATE_W-1:0] rate,
                                         logic [STAMP_W-1:0] now);
    bucket_t b;
    b.rate      = rate;
    b.tokens    = rate_unlimited(kind, rate) ? FULL_UNLIMITED : {1'b0, rate, 1'b0};
    b.stamp     = now;
    b.throttled = '0;
    return b;
  endfunction

endpackage

/* design/pctbq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pctbq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/per_client_token_bucket_quota.sv */
// Top level of the per-client token bucket quota block.

// Each client slot owns a produce, a fetch and a request token bucket (Q26.8),
// kept as one row of a table RAM; the first non-anonymous check or override on
// a slot creates all three buckets full at the global default rates. For a
// request, the accept edge reads the client row, the multiply state forms the
// elapsed-time times rate product, and the update state refills, takes or
// throttles, writes the row back and loads the result register. The next request
// is taken the cycle after the update, so no new request is accepted before the
// last one is through; a held result only stalls the update cycle. Slot valid bits are flip-flops
// cleared by reset, so no clearing pass runs and requests are taken right after
// reset. Configuration writes take effect at once and are meant for idle times.
`timescale 1ns / 1ps
`include "per_client_token_bucket_quota_macros.svh"

module per_client_token_bucket_quota #(
  parameter int CLIENTS = pctbq_pkg::CLIENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // client_slot[5:0], rate_value[37:6], zero pad[39:38]
  input  logic [pctbq_pkg::IN_TDATA_W-1:0]    s_tdata,
  // op[2:0], anonymous[3]
  input  logic [pctbq_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tokens_whole[25:0], client_throttles[57:26], total_throttles[89:58], zero pad[95:90]
  output logic [pctbq_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // allowed[0]
  output logic [pctbq_pkg::OUT_TUSER_W-1:0]   m_tuser,
  input  logic                                cfg_we,
  input  logic [pctbq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pctbq_pkg::RATE_W-1:0]        cfg_data
);
  import pctbq_pkg::*;

  // Only slots reachable through the slot field get storage
  localparam int SLOTS  = (CLIENTS < (1 << SLOT_FIELD_W)) ? CLIENTS : (1 << SLOT_FIELD_W);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic [RATE_W-1:0]       dflt_rate [KINDS];
  logic [STAMP_W-1:0]      time_now;
  logic [SLOTS-1:0]        valid;
  logic [CNT_W-1:0]        kind_cnt [KINDS];

  // Request held through the update
  op_t                     req_op;
  logic [SLOT_FIELD_W-1:0] req_slot;
  logic                    req_anon;
  logic [RATE_W-1:0]       req_value;
  logic                    req_in_range;

  // Values from the multiply cycle
  row_t                    row_q;
  kind_t                   kind_q;
  logic                    elapsed_nz_q;
  logic [PROD_W-1:0]       gain_q;

  logic                    accept;
  logic                    upd_fire;
  logic                    upd_stall;
  logic [SLOT_FIELD_W-1:0] in_slot;
  logic                    in_in_range;
  logic [SLOT_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       slot_idx;
  logic [ROW_W-1:0]        rd_data;
  logic                    ram_we;

  row_t                    eff_row;
  bucket_t                 mul_b;
  kind_t                   mul_kind;
  logic [STAMP_W-1:0]      elapsed;

  bucket_t                 b;
  bucket_t                 nb;
  row_t                    new_row;
  logic [TOKEN_W-1:0]      burst;
  logic [TOKEN_W:0]        sum;
  logic [TOKEN_W-1:0]      refilled;
  logic                    has_token;
  logic                    is_check;
  logic                    is_set;
  logic                    do_bucket;
  logic                    limited_check;
  logic                    throttle;
  logic [CNT_W-1:0]        kcnt_new;
  logic                    out_allowed;
  logic [WHOLE_W-1:0]      out_tokens;
  logic [CNT_W-1:0]        out_cthr;
  logic [CNT_W-1:0]        out_tthr;

  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign upd_fire    = (state == ST_UPD) && (!m_tvalid || m_tready);
  assign upd_stall   = (state == ST_UPD) && !upd_fire;
  assign in_slot     = s_tdata[SLOT_FIELD_W-1:0];
  assign in_in_range = ({1'b0, in_slot} < (SLOT_FIELD_W + 1)'(SLOTS));
  assign rd_addr     = in_in_range ? in_slot[SLOT_W-1:0] : '0;
  assign slot_idx    = req_slot[SLOT_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_UPD;
      ST_UPD: begin
        if (upd_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  pctbq_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (new_row),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Multiply cycle: substitute a freshly created row for an unknown client
  always_comb begin
    mul_kind = kind_of(req_op);
    if (req_in_range && valid[slot_idx]) begin
      eff_row = row_t'(rd_data);
    end else begin
      eff_row[KIND_PRODUCE] = new_bucket(KIND_PRODUCE, dflt_rate[KIND_PRODUCE], time_now);
      eff_row[KIND_FETCH]   = new_bucket(KIND_FETCH,   dflt_rate[KIND_FETCH],   time_now);
      eff_row[KIND_REQUEST] = new_bucket(KIND_REQUEST, dflt_rate[KIND_REQUEST], time_now);
    end
    mul_b   = eff_row[mul_kind];
    elapsed = time_now - mul_b.stamp;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op       <= op_t'(s_tuser[OP_W-1:0]);
      req_anon     <= s_tuser[OP_W];
      req_slot     <= in_slot;
      req_value    <= s_tdata[SLOT_FIELD_W +: RATE_W];
      req_in_range <= in_in_range;
    end
    if (state == ST_MUL) begin
      row_q        <= eff_row;
      kind_q       <= mul_kind;
      elapsed_nz_q <= (elapsed != '0);
      gain_q       <= elapsed * mul_b.rate;
    end
  end

  // Update cycle: refill, take a token or throttle
  always_comb begin
    b             = row_q[kind_q];
    is_check      = (req_op == OP_CHK_PRODUCE) || (req_op == OP_CHK_FETCH) ||
                    (req_op == OP_CHK_REQUEST);
    is_set        = (req_op == OP_SET_PRODUCE) || (req_op == OP_SET_FETCH) ||
                    (req_op == OP_SET_REQUEST);
    do_bucket     = req_in_range && ((is_check && !req_anon) || is_set);
    limited_check = do_bucket && is_check && !rate_unlimited(kind_q, b.rate);
    burst         = {1'b0, b.rate, 1'b0};
    sum           = {1'b0, b.tokens} + {2'b00, gain_q[TOKEN_W-2:0]};
    if (!elapsed_nz_q) begin
      refilled = b.tokens;
    end else if (gain_q >= {{(PROD_W - TOKEN_W){1'b0}}, burst}) begin
      refilled = burst;
    end else if (sum > {1'b0, burst}) begin
      refilled = burst;
    end else begin
      refilled = sum[TOKEN_W-1:0];
    end
    has_token = (refilled >= ONE_TOKEN);
    throttle  = limited_check && !has_token;

    nb = b;
    if (limited_check) begin
      nb.stamp  = time_now;
      nb.tokens = has_token ? refilled - ONE_TOKEN : refilled;
      if (!has_token) nb.throttled = sat_inc(b.throttled);
    end
    if (is_set) begin
      nb.rate = req_value;
    end
    new_row         = row_q;
    new_row[kind_q] = nb;

    kcnt_new    = throttle ? sat_inc(kind_cnt[kind_q]) : kind_cnt[kind_q];
    out_allowed = !throttle;
    out_tokens  = do_bucket ? nb.tokens[TOKEN_W-1:FRAC_W] : '0;
    out_cthr    = do_bucket ? nb.throttled : '0;
    out_tthr    = (do_bucket || is_check) ? kcnt_new : '0;
  end

  assign ram_we = upd_fire && do_bucket;

  // Control state: clients, time, global counters, defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      valid    <= '0;
      for (int k = 0; k < KINDS; k++) begin
        kind_cnt[k]  <= '0;
        dflt_rate[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PRODUCE_RATE: dflt_rate[KIND_PRODUCE] <= cfg_data;
          CFG_FETCH_RATE:   dflt_rate[KIND_FETCH]   <= cfg_data;
          CFG_REQUEST_RATE: dflt_rate[KIND_REQUEST] <= cfg_data;
          default: ;
        endcase
      end
      if (upd_fire) begin
        if (req_op == OP_TICK) time_now <= time_now + 1'b1;
        if (do_bucket) valid[slot_idx] <= 1'b1;
        if ((req_op == OP_REMOVE) && req_in_range) valid[slot_idx] <= 1'b0;
        if (throttle) kind_cnt[kind_q] <= kcnt_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      m_tdata <= {{(OUT_TDATA_W - WHOLE_W - 2 * CNT_W){1'b0}}, out_tthr, out_cthr, out_tokens};
      m_tuser <= out_allowed;
    end
  end

  `PCTBQ_ASSERT_NEXT(a_accept_reads_row, accept, state == ST_MUL, "no row read after accept")
  `PCTBQ_ASSERT_NEXT(a_upd_result, upd_fire, m_tvalid && (state == ST_IDLE), "result not loaded")
  `PCTBQ_ASSERT_NEXT(a_upd_hold, upd_stall, (state == ST_UPD) && m_tvalid, "stall not held")

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the per-client token bucket quota block.
`timescale 1ns / 1ps

module tb_top;
  import pctbq_pkg::*;

  localparam int NUM_SLOTS   = 64;
  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE_CYC  = 6;

  typedef struct packed {
    logic                   allowed;
    logic [WHOLE_W-1:0]     tokens_whole;
    logic [CNT_W-1:0]       client_throttles;
    logic [CNT_W-1:0]       total_throttles;
  } quota_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;   // client_slot[5:0], rate_value[37:6], zero pad[39:38]
  logic [IN_TUSER_W-1:0] s_tuser;   // op[2:0], anonymous[3]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;  // tokens_whole, client_throttles, total_throttles, pad
  logic [OUT_TUSER_W-1:0] m_tuser;  // allowed[0]
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [RATE_W-1:0] cfg_data;

  per_client_token_bucket_quota u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quota predictor state
  logic [RATE_W-1:0]  dflt_rate [KINDS];
  logic [STAMP_W-1:0] now_tick;
  logic               slot_live [NUM_SLOTS];
  logic [RATE_W-1:0]  bkt_rate [NUM_SLOTS][KINDS];
  logic [TOKEN_W-1:0] bkt_tokens [NUM_SLOTS][KINDS];
  logic [STAMP_W-1:0] bkt_stamp [NUM_SLOTS][KINDS];
  logic [CNT_W-1:0]   bkt_throttles [NUM_SLOTS][KINDS];
  logic [CNT_W-1:0]   kind_throttles [KINDS];

  quota_result_t expected_results [$];
  int  mismatches = 0;
  int  ready_hold = 0;
  int  stall_cycles = 0;
  logic gaps_on = 1'b1;

  function automatic logic rate_is_free(int kind, logic [RATE_W-1:0] rate);
    return (rate == '0) || (kind == int'(KIND_REQUEST) && rate >= REQ_UNLIMITED_RATE);
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic open_client(int s);
    for (int k = 0; k < KINDS; k++) begin
      bkt_rate[s][k]      = dflt_rate[k];
      bkt_tokens[s][k]    = rate_is_free(k, dflt_rate[k]) ? FULL_UNLIMITED
                                                          : {1'b0, dflt_rate[k], 1'b0};
      bkt_stamp[s][k]     = now_tick;
      bkt_throttles[s][k] = '0;
    end
    slot_live[s] = 1'b1;
  endtask

  // Lazy refill: only when time moved, clamp to a burst of two ticks of rate
  task automatic refill_bucket(int s, int k);
    logic [STAMP_W-1:0] elapsed;
    logic [65:0] burst;
    logic [65:0] gain;
    logic [65:0] level;
    elapsed = now_tick - bkt_stamp[s][k];
    if (elapsed != '0) begin
      burst = 66'(bkt_rate[s][k]) << 1;
      gain  = 66'(elapsed) * 66'(bkt_rate[s][k]);
      if (gain >= burst) begin
        level = burst;
      end else begin
        level = 66'(bkt_tokens[s][k]) + gain;
        if (level > burst) level = burst;
      end
      bkt_tokens[s][k] = level[TOKEN_W-1:0];
    end
    bkt_stamp[s][k] = now_tick;
  endtask

  task automatic predict_quota_result(op_t op, logic [5:0] slot, logic anon,
                                      logic [RATE_W-1:0] rate_in);
    quota_result_t r;
    int s;
    int k;
    r = '0;
    r.allowed = 1'b1;
    s = int'(slot);
    case (op)
      OP_TICK: begin
        now_tick = now_tick + 1'b1;
      end
      OP_CHK_PRODUCE, OP_CHK_FETCH, OP_CHK_REQUEST: begin
        k = int'(op) - int'(OP_CHK_PRODUCE);
        r.total_throttles = kind_throttles[k];
        if (!anon) begin
          if (!slot_live[s]) open_client(s);
          if (!rate_is_free(k, bkt_rate[s][k])) begin
            refill_bucket(s, k);
            if (bkt_tokens[s][k] >= ONE_TOKEN) begin
              bkt_tokens[s][k] = bkt_tokens[s][k] - ONE_TOKEN;
            end else begin
              r.allowed = 1'b0;
              bkt_throttles[s][k] = bump(bkt_throttles[s][k]);
              kind_throttles[k]   = bump(kind_throttles[k]);
            end
          end
          r.tokens_whole     = bkt_tokens[s][k][TOKEN_W-1:FRAC_W];
          r.client_throttles = bkt_throttles[s][k];
          r.total_throttles  = kind_throttles[k];
        end
      end
      OP_SET_PRODUCE, OP_SET_FETCH, OP_SET_REQUEST: begin
        k = int'(op) - int'(OP_SET_PRODUCE);
        if (!slot_live[s]) open_client(s);
        bkt_rate[s][k]     = rate_in;
        r.tokens_whole     = bkt_tokens[s][k][TOKEN_W-1:FRAC_W];
        r.client_throttles = bkt_throttles[s][k];
        r.total_throttles  = kind_throttles[k];
      end
      default: begin
        slot_live[s] = 1'b0;
      end
    endcase
    expected_results.push_back(r);
  endtask

  // Hold the request until accepted, with an optional idle burst in front
  task automatic send_request(op_t op, logic [5:0] slot, logic anon,
                              logic [RATE_W-1:0] rate_in);
    int gap;
    gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, rate_in, slot};
    s_tuser  = {anon, op};
    do @(posedge clk); while (!s_tready);
    predict_quota_result(op, slot, anon, rate_in);
  endtask

  // Drop valid and wait until every result is back and the block has settled
  task automatic drain_requests();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_default_rate(cfg_reg_t idx, logic [RATE_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    dflt_rate[int'(idx)] = value;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(25590, 25610);
      2:       return '0;
      default: return $urandom_range(1, 2048);
    endcase
  endfunction

  task automatic random_requests(int count, int slot_span);
    op_t op;
    int  pick;
    logic [5:0] slot;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18)      op = OP_TICK;
      else if (pick < 72) op = op_t'($urandom_range(int'(OP_CHK_PRODUCE), int'(OP_CHK_REQUEST)));
      else if (pick < 92) op = op_t'($urandom_range(int'(OP_SET_PRODUCE), int'(OP_SET_REQUEST)));
      else                op = OP_REMOVE;
      slot = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, NUM_SLOTS - 1))
                                         : 6'($urandom_range(0, slot_span - 1));
      send_request(op, slot, $urandom_range(0, 9) == 0, pick_rate());
      if ($urandom_range(0, 199) == 0) drain_requests();
    end
  endtask

  task automatic test_unlimited_defaults();
    send_request(OP_CHK_PRODUCE, 6'd3, 1'b0, 32'h0);
    send_request(OP_CHK_FETCH, 6'd3, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_CHK_REQUEST, 6'd3, 1'b0, 32'h0);
    drain_requests();
  endtask

  task automatic test_directed_buckets();
    set_default_rate(CFG_PRODUCE_RATE, 32'd256);
    set_default_rate(CFG_FETCH_RATE, 32'd640);
    set_default_rate(CFG_REQUEST_RATE, 32'd512);
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b0, 32'h0);
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b0, 32'h0);
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b0, 32'h0);   // bucket empty: throttle
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b1, 32'h0);   // anonymous passes
    send_request(OP_TICK, 6'd0, 1'b0, 32'h0);
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b0, 32'h0);
    send_request(OP_CHK_FETCH, 6'd63, 1'b0, 32'h0);
    send_request(OP_CHK_REQUEST, 6'd63, 1'b0, 32'h0);
    send_request(OP_SET_PRODUCE, 6'd0, 1'b0, 32'h0);   // zero rate: unlimited
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b0, 32'h0);
    send_request(OP_SET_REQUEST, 6'd5, 1'b0, 32'd25600);
    send_request(OP_CHK_REQUEST, 6'd5, 1'b0, 32'h0);
    send_request(OP_SET_REQUEST, 6'd5, 1'b0, 32'd25599);
    send_request(OP_CHK_REQUEST, 6'd5, 1'b0, 32'h0);
    send_request(OP_SET_FETCH, 6'd42, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_TICK, 6'd42, 1'b1, 32'hFFFF_FFFF);
    send_request(OP_CHK_FETCH, 6'd42, 1'b0, 32'h0);
    send_request(OP_REMOVE, 6'd0, 1'b0, 32'h0);
    send_request(OP_REMOVE, 6'd0, 1'b1, 32'h0);
    send_request(OP_CHK_PRODUCE, 6'd0, 1'b0, 32'h0);   // recreated full
    send_request(OP_SET_FETCH, 6'd21, 1'b1, 32'hAAAA_5555);
    drain_requests();
  endtask

  task automatic test_extreme_rates();
    set_default_rate(CFG_PRODUCE_RATE, 32'hFFFF_FFFF);
    set_default_rate(CFG_FETCH_RATE, 32'hFFFF_FFFF);
    set_default_rate(CFG_REQUEST_RATE, 32'd25600);
    random_requests(150, 16);
    drain_requests();
    set_default_rate(CFG_PRODUCE_RATE, 32'd1);
    set_default_rate(CFG_FETCH_RATE, 32'd255);
    set_default_rate(CFG_REQUEST_RATE, 32'd25599);
    random_requests(250, 8);
    drain_requests();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase != 2);
      set_default_rate(CFG_PRODUCE_RATE, pick_rate());
      set_default_rate(CFG_FETCH_RATE, pick_rate());
      set_default_rate(CFG_REQUEST_RATE, pick_rate());
      random_requests(225, (phase == 3) ? NUM_SLOTS : 8);
      drain_requests();
    end
  endtask

  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    random_requests(200, 8);
    drain_requests();
  endtask

  // Receiver side: random stall bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      m_tready = 1'b0;
      ready_hold--;
    end else begin
      m_tready = 1'b1;
      if (gaps_on && $urandom_range(0, 7) == 0) ready_hold = $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin
    quota_result_t got;
    quota_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.allowed          = m_tuser[0];
      got.tokens_whole     = m_tdata[25:0];
      got.client_throttles = m_tdata[57:26];
      got.total_throttles  = m_tdata[89:58];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp/act: allowed %0d/%0d tokens %0d/%0d client %0d/%0d total %0d/%0d",
                     want.allowed, got.allowed, want.tokens_whole, got.tokens_whole,
                     want.client_throttles, got.client_throttles,
                     want.total_throttles, got.total_throttles);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PRODUCE_RATE;
    cfg_data  = '0;
    now_tick  = '0;
    for (int k = 0; k < KINDS; k++) begin
      dflt_rate[k]      = '0;
      kind_throttles[k] = '0;
    end
    for (int s = 0; s < NUM_SLOTS; s++) slot_live[s] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_unlimited_defaults();
    test_directed_buckets();
    test_extreme_rates();
    test_random_traffic();
    test_quiet_tail();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
